>>> rtl/core/tape_machine_instruction_step_macros.svh
// Assertion macros for the tape machine instruction step block.
`ifndef TAPE_MACHINE_INSTRUCTION_STEP_MACROS_SVH
`define TAPE_MACHINE_INSTRUCTION_STEP_MACROS_SVH

// Check a same-cycle implication on clk, disabled during rst.
`define TMIS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the following cycle on clk, disabled during rst.
`define TMIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/tmis_pkg.sv
// Shared types, opcodes, status codes and defaults for the tape machine step block.
`default_nettype none

package tmis_pkg;

  localparam int DEF_TAPE_CELLS  = 1024;
  localparam int DEF_STACK_DEPTH = 128;
  localparam int DEF_ADDR_BITS   = 16;

  localparam int FIELD_ADDR_W = 16;
  localparam logic [16:0] RUN_LEN  = 17'd5;
  localparam logic [15:0] SKIP_MAX = 16'hFFFF;

  localparam logic [4:0] OP_PTR_INC   = 5'd0;
  localparam logic [4:0] OP_PTR_DEC   = 5'd1;
  localparam logic [4:0] OP_VAL_INC   = 5'd2;
  localparam logic [4:0] OP_VAL_DEC   = 5'd3;
  localparam logic [4:0] OP_PTR_ADD_N = 5'd4;
  localparam logic [4:0] OP_PTR_SUB_N = 5'd5;
  localparam logic [4:0] OP_VAL_ADD_N = 5'd6;
  localparam logic [4:0] OP_VAL_SUB_N = 5'd7;
  localparam logic [4:0] OP_ZERO      = 5'd8;
  localparam logic [4:0] OP_ONE       = 5'd9;
  localparam logic [4:0] OP_OUT       = 5'd10;
  localparam logic [4:0] OP_IN        = 5'd11;
  localparam logic [4:0] OP_OPEN      = 5'd12;
  localparam logic [4:0] OP_CLOSE     = 5'd13;
  localparam logic [4:0] OP_JZ        = 5'd14;
  localparam logic [4:0] OP_JNZ       = 5'd15;
  localparam logic [4:0] OP_END       = 5'd16;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DATA_OVF  = 3'd1;
  localparam logic [2:0] ST_DATA_UNF  = 3'd2;
  localparam logic [2:0] ST_STK_OVF   = 3'd3;
  localparam logic [2:0] ST_STK_UNF   = 3'd4;
  localparam logic [2:0] ST_END       = 3'd5;
  localparam logic [2:0] ST_PAST_END  = 3'd6;

  typedef struct packed {
    logic [4:0]  opcode;
    logic [15:0] operand;
    logic [15:0] instr_addr;
    logic [7:0]  in_byte;
  } item_t;

  typedef struct packed {
    logic [15:0] next_addr;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic [2:0]  status;
  } result_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_op_t;

endpackage

`default_nettype wire

>>> rtl/core/tape_machine_instruction_step.sv
// Tape machine instruction step: executes one tape-machine instruction per transaction.
//
// Input channel item_valid/item_ready carries opcode, operand, instr_addr and in_byte.
// Output channel result_valid/result_ready carries next_addr, out_valid, out_byte and
// status, one result per instruction, in order.
// cfg_wr_en/cfg_wr_data write program_length in the cycle they are high.
// A transaction accepted at a clock edge is registered into the execute stage; its
// result is registered onto the outputs, raising result_valid, when that stage fires.
// Throughput: one instruction per cycle outside the sweep while results are taken. The
// tape and the return stack each have one read and one write port; a cell or stack entry
// written by one instruction is forwarded to the next one, so no bubble is needed.
// Reset: rst clears pointers, skip depth and error state, then a sweep zeroes the
// tape one cell per cycle, all TAPE_CELLS cells, with item_ready low. Config writes
// are taken during the sweep.
// Stall: while result_ready is low the result is held; one more instruction can wait
// in the execute stage, then item_ready drops until the result is taken.
// Any nonzero status is sticky: later instructions return their own address and
// that status until reset.
`default_nettype none

`include "tape_machine_instruction_step_macros.svh"

module tape_machine_instruction_step import tmis_pkg::*; #(
  parameter int TAPE_CELLS  = DEF_TAPE_CELLS,
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int ADDR_BITS   = DEF_ADDR_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic [4:0]  opcode,
  input  wire logic [15:0] operand,
  input  wire logic [15:0] instr_addr,
  input  wire logic [7:0]  in_byte,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic [15:0]      next_addr,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic [2:0]       status
);

  localparam int DW = $clog2(TAPE_CELLS);
  localparam int SW = $clog2(STACK_DEPTH);

  item_t                   e_item;
  logic                    e_valid;
  logic                    e_fire;
  logic                    accept;
  result_t                 exec_res;
  logic [2:0]              err;
  logic                    tape_busy;
  mem_op_t                 tape_op;
  logic [DW-1:0]           tape_rd_addr;
  logic [DW-1:0]           tape_wr_addr;
  logic [7:0]              tape_wr_data;
  logic [7:0]              cur_cell;
  mem_op_t                 stk_op;
  logic [SW-1:0]           stk_rd_addr;
  logic [SW-1:0]           stk_wr_addr;
  logic [FIELD_ADDR_W-1:0] stk_wr_data;
  logic [FIELD_ADDR_W-1:0] top;

  assign e_fire     = e_valid && (!result_valid || result_ready);
  assign item_ready = !tape_busy && (!e_valid || e_fire);
  assign accept     = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_ready) e_valid <= item_valid;
      if (e_fire) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
    if (accept) begin
      e_item.opcode     <= opcode;
      e_item.operand    <= operand;
      e_item.instr_addr <= instr_addr;
      e_item.in_byte    <= in_byte;
    end
    if (e_fire) begin
      next_addr <= exec_res.next_addr;
      out_valid <= exec_res.out_valid;
      out_byte  <= exec_res.out_byte;
      status    <= exec_res.status;
    end
  end

  tmis_exec #(
    .TAPE_CELLS  (TAPE_CELLS),
    .STACK_DEPTH (STACK_DEPTH),
    .ADDR_BITS   (ADDR_BITS)
  ) u_exec (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .accept       (accept),
    .fire         (e_fire),
    .item         (e_item),
    .cur_cell     (cur_cell),
    .top          (top),
    .res          (exec_res),
    .err          (err),
    .tape_op      (tape_op),
    .tape_rd_addr (tape_rd_addr),
    .tape_wr_addr (tape_wr_addr),
    .tape_wr_data (tape_wr_data),
    .stk_op       (stk_op),
    .stk_rd_addr  (stk_rd_addr),
    .stk_wr_addr  (stk_wr_addr),
    .stk_wr_data  (stk_wr_data)
  );

  tmis_tape #(
    .TAPE_CELLS (TAPE_CELLS)
  ) u_tape (
    .clk     (clk),
    .rst     (rst),
    .op      (tape_op),
    .rd_addr (tape_rd_addr),
    .wr_addr (tape_wr_addr),
    .wr_data (tape_wr_data),
    .rd_data (cur_cell),
    .busy    (tape_busy)
  );

  tmis_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .rst     (rst),
    .op      (stk_op),
    .rd_addr (stk_rd_addr),
    .wr_addr (stk_wr_addr),
    .wr_data (stk_wr_data),
    .rd_data (top)
  );

  `TMIS_ASSERT_NOW(a_no_accept_in_sweep, tape_busy, !item_ready, "item accepted during tape sweep")
  `TMIS_ASSERT_NEXT(a_err_sticky, !rst && err != ST_OK, err == $past(err), "error state changed")
  `TMIS_ASSERT_NOW(a_err_result, e_fire && err != ST_OK, exec_res.status == err && !exec_res.out_valid, "sticky error result wrong")
  `TMIS_ASSERT_NOW(a_out_only_on_out, exec_res.out_valid, e_item.opcode == OP_OUT, "output byte from non-output op")

endmodule

`default_nettype wire

>>> rtl/core/tmis_tape.sv
// Tape memory: registered read, write forwarding and a clearing sweep after reset.
`default_nettype none

module tmis_tape import tmis_pkg::*; #(
  parameter int TAPE_CELLS = DEF_TAPE_CELLS,
  localparam int DW = $clog2(TAPE_CELLS)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mem_op_t       op,
  input  wire logic [DW-1:0] rd_addr,
  input  wire logic [DW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  output logic [7:0]         rd_data,
  output logic               busy
);

  logic [7:0]    mem [TAPE_CELLS];
  logic [7:0]    rd_q;
  logic [DW-1:0] clr_addr;
  logic          fwd;
  logic [7:0]    fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == DW'(TAPE_CELLS - 1)) begin
        busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= 8'd0;
    end else if (op.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (op.rd) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (op.rd) begin
      fwd <= op.wr && (wr_addr == rd_addr);
    end
    if (op.rd) begin
      fwd_data <= wr_data;
    end
  end

  assign rd_data = fwd ? fwd_data : rd_q;

endmodule

`default_nettype wire

>>> rtl/core/tmis_stack.sv
// Return stack memory: registered read of the top entry with push forwarding.
`default_nettype none

module tmis_stack import tmis_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  localparam int SW = $clog2(STACK_DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire mem_op_t                 op,
  input  wire logic [SW-1:0]           rd_addr,
  input  wire logic [SW-1:0]           wr_addr,
  input  wire logic [FIELD_ADDR_W-1:0] wr_data,
  output logic [FIELD_ADDR_W-1:0]      rd_data
);

  logic [FIELD_ADDR_W-1:0] mem [STACK_DEPTH];
  logic [FIELD_ADDR_W-1:0] rd_q;
  logic                    fwd;
  logic [FIELD_ADDR_W-1:0] fwd_data;

  always_ff @(posedge clk) begin
    if (op.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (op.rd) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (op.rd) begin
      fwd <= op.wr && (wr_addr == rd_addr);
    end
    if (op.rd) begin
      fwd_data <= wr_data;
    end
  end

  assign rd_data = fwd ? fwd_data : rd_q;

endmodule

`default_nettype wire

>>> rtl/core/tmis_exec.sv
// Execute stage: instruction decode, machine state registers and memory requests.
`default_nettype none

module tmis_exec import tmis_pkg::*; #(
  parameter int TAPE_CELLS  = DEF_TAPE_CELLS,
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int ADDR_BITS   = DEF_ADDR_BITS,
  localparam int DW = $clog2(TAPE_CELLS),
  localparam int SW = $clog2(STACK_DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_wr_en,
  input  wire logic [15:0]             cfg_wr_data,
  input  wire logic                    accept,
  input  wire logic                    fire,
  input  wire item_t                   item,
  input  wire logic [7:0]              cur_cell,
  input  wire logic [FIELD_ADDR_W-1:0] top,
  output result_t                      res,
  output logic [2:0]                   err,
  output mem_op_t                      tape_op,
  output logic [DW-1:0]                tape_rd_addr,
  output logic [DW-1:0]                tape_wr_addr,
  output logic [7:0]                   tape_wr_data,
  output mem_op_t                      stk_op,
  output logic [SW-1:0]                stk_rd_addr,
  output logic [SW-1:0]                stk_wr_addr,
  output logic [FIELD_ADDR_W-1:0]      stk_wr_data
);

  localparam int AW = (ADDR_BITS < FIELD_ADDR_W) ? ADDR_BITS : FIELD_ADDR_W;
  localparam logic [15:0] AMASK = 16'((32'd1 << AW) - 32'd1);
  localparam int WS = ((DW > 16) ? DW : 16) + 1;

  logic [DW-1:0] dp, dp_next;
  logic [SW:0]   sp, sp_next, rd_sp;
  logic [15:0]   skip, skip_next;
  logic [15:0]   prog_len;
  logic [15:0]   addr_m;
  logic [16:0]   nxt;
  logic [2:0]    status;
  logic          act;
  logic          upd;
  logic          t_wr;
  logic          s_wr;
  logic          ov;
  logic [WS-1:0] sum_up;

  always_comb begin
    act          = (skip == 16'd0);
    addr_m       = item.instr_addr & AMASK;
    nxt          = {1'b0, addr_m} + 17'd1;
    status       = ST_OK;
    ov           = 1'b0;
    dp_next      = dp;
    sp_next      = sp;
    skip_next    = skip;
    t_wr         = 1'b0;
    s_wr         = 1'b0;
    tape_wr_data = cur_cell;
    sum_up       = WS'(dp) + WS'(item.operand);
    unique case (item.opcode)
      OP_PTR_INC: begin
        if (act) begin
          if (dp == DW'(TAPE_CELLS - 1)) status = ST_DATA_OVF;
          else dp_next = dp + 1'b1;
        end
      end
      OP_PTR_DEC: begin
        if (act) begin
          if (dp == '0) status = ST_DATA_UNF;
          else dp_next = dp - 1'b1;
        end
      end
      OP_VAL_INC: begin
        t_wr = act;
        tape_wr_data = cur_cell + 8'd1;
      end
      OP_VAL_DEC: begin
        t_wr = act;
        tape_wr_data = cur_cell - 8'd1;
      end
      OP_PTR_ADD_N: begin
        nxt = {1'b0, addr_m} + RUN_LEN;
        if (act) begin
          if (sum_up >= WS'(TAPE_CELLS)) status = ST_DATA_OVF;
          else dp_next = DW'(sum_up);
        end
      end
      OP_PTR_SUB_N: begin
        nxt = {1'b0, addr_m} + RUN_LEN;
        if (act) begin
          if (WS'(item.operand) > WS'(dp)) status = ST_DATA_UNF;
          else dp_next = dp - DW'(item.operand);
        end
      end
      OP_VAL_ADD_N: begin
        nxt = {1'b0, addr_m} + RUN_LEN;
        t_wr = act;
        tape_wr_data = cur_cell + item.operand[7:0];
      end
      OP_VAL_SUB_N: begin
        nxt = {1'b0, addr_m} + RUN_LEN;
        t_wr = act;
        tape_wr_data = cur_cell - item.operand[7:0];
      end
      OP_ZERO: begin
        t_wr = act;
        tape_wr_data = 8'd0;
      end
      OP_ONE: begin
        t_wr = act;
        tape_wr_data = 8'd1;
      end
      OP_OUT: begin
        ov = act;
      end
      OP_IN: begin
        t_wr = act;
        tape_wr_data = item.in_byte;
      end
      OP_OPEN: begin
        if (!act) begin
          if (skip != SKIP_MAX) skip_next = skip + 16'd1;
        end else if (cur_cell == 8'd0) begin
          skip_next = 16'd1;
        end else if (sp == (SW + 1)'(STACK_DEPTH)) begin
          status = ST_STK_OVF;
        end else begin
          s_wr    = 1'b1;
          sp_next = sp + 1'b1;
        end
      end
      OP_CLOSE: begin
        if (!act) begin
          skip_next = skip - 16'd1;
        end else if (sp == '0) begin
          status = ST_STK_UNF;
        end else if (cur_cell != 8'd0) begin
          nxt = {1'b0, top} + 17'd1;
        end else begin
          sp_next = sp - 1'b1;
        end
      end
      OP_JZ: begin
        nxt = {1'b0, addr_m} + RUN_LEN;
        if (act && cur_cell == 8'd0) nxt = {1'b0, item.operand} + 17'd1;
      end
      OP_JNZ: begin
        nxt = {1'b0, addr_m} + RUN_LEN;
        if (act && cur_cell != 8'd0) nxt = {1'b0, item.operand};
      end
      OP_END: begin
        status = ST_END;
      end
      default: ;
    endcase
    if (status == ST_OK && nxt >= {1'b0, prog_len}) status = ST_PAST_END;
  end

  always_comb begin
    if (err != ST_OK) begin
      res.next_addr = addr_m;
      res.out_valid = 1'b0;
      res.out_byte  = 8'd0;
      res.status    = err;
    end else begin
      res.next_addr = nxt[15:0] & AMASK;
      res.out_valid = ov;
      res.out_byte  = ov ? cur_cell : 8'd0;
      res.status    = status;
    end
  end

  assign upd          = fire && (err == ST_OK);
  assign rd_sp        = upd ? sp_next : sp;
  assign tape_op.rd   = accept;
  assign tape_op.wr   = upd && t_wr;
  assign tape_rd_addr = upd ? dp_next : dp;
  assign tape_wr_addr = dp;
  assign stk_op.rd    = accept && (rd_sp != '0);
  assign stk_op.wr    = upd && s_wr;
  assign stk_rd_addr  = SW'(rd_sp - 1'b1);
  assign stk_wr_addr  = sp[SW-1:0];
  assign stk_wr_data  = addr_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      dp       <= '0;
      sp       <= '0;
      skip     <= '0;
      err      <= ST_OK;
      prog_len <= '0;
    end else begin
      if (cfg_wr_en) prog_len <= cfg_wr_data;
      if (upd) begin
        dp   <= dp_next;
        sp   <= sp_next;
        skip <= skip_next;
        if (status != ST_OK) err <= status;
      end
    end
  end

endmodule

`default_nettype wire
